@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define PLE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");
`define PLE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");
`else
`define PLE_ASSERT(lbl, clk, rst_n, prop)
`define PLE_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ rtl/ple_pkg.sv @@
// ----------------------------------------------------------------------------
// ple_pkg
// Shared constants and types of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int CAPACITY    = 64;
    localparam int ENTRY_WIDTH = 16;

    localparam int REQ_W   = 3;
    localparam int POS_W   = 7;
    localparam int VALUE_W = 16;
    localparam int IDX_W   = 6;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 7;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;

    typedef enum logic [REQ_W-1:0] {
        REQ_GET     = 3'd0,
        REQ_INSERT  = 3'd1,
        REQ_REMOVE  = 3'd2,
        REQ_REPLACE = 3'd3,
        REQ_SEARCH  = 3'd4,
        REQ_CLEAR   = 3'd5
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_BADPOS   = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        MODE_READ    = 3'd0,
        MODE_INSERT  = 3'd1,
        MODE_REMOVE  = 3'd2,
        MODE_REPLACE = 3'd3,
        MODE_SEARCH  = 3'd4
    } t_mode;

    typedef struct packed {
        logic  en;
        t_mode mode;
    } t_cell_ctl;

endpackage

@@ rtl/positional_list_engine_top.sv @@
// A result word passes from the cell row through each level of the registered
// first-hit tree, which serves get, remove and search, into the output register.
// One request is taken at a time: the next is accepted only after the result
// word of the last has been loaded, which waits while the output is stalled.
// Reset (i_rst_n low, synchronous) empties the list and drops any pending word.
// ----------------------------------------------------------------------------
// positional_list_engine_top
// Ordered list held in a row of shifting cells with a first-hit tree.
// ----------------------------------------------------------------------------
module positional_list_engine_top #(
    parameter int CAPACITY    = ple_pkg::CAPACITY,
    parameter int ENTRY_WIDTH = ple_pkg::ENTRY_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // req_type[2:0], position[9:3], at_end[10], value[26:11]
    input  logic [ple_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // read_value[15:0], found_index[21:16], status[23:22], entry_count[30:24]
    output logic [ple_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);

    `include "assert_macros.svh"

    localparam int EW   = ENTRY_WIDTH;
    localparam int L    = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;
    localparam int TW   = $clog2(L + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [TW-1:0]       r_cnt;
    logic [ple_pkg::REQ_W-1:0] r_req;
    ple_pkg::t_status    r_stat, n_stat;
    logic                r_out_valid;
    logic [ple_pkg::M_TDATA_W-1:0] r_out_data, n_out_data;

    logic [ple_pkg::REQ_W-1:0]   w_req;
    logic [ple_pkg::POS_W-1:0]   w_pos;
    logic                        w_at_end;
    logic [ple_pkg::VALUE_W-1:0] w_value;
    logic [CMPW-1:0]             w_eff_pos, w_count_x;
    logic [EW-1:0]               w_val;
    ple_pkg::t_mode              n_mode;
    ple_pkg::t_cell_ctl          w_ctl;
    logic                        w_in_acc, w_out_load;

    logic [EW-1:0]  w_entry [CAPACITY];
    logic [EW-1:0]  w_ldata [CAPACITY];
    logic [CAPACITY-1:0] w_lhit;
    logic           w_root_hit;
    logic [L-1:0]   w_root_idx;
    logic [EW-1:0]  w_root_data;

    logic [ple_pkg::VALUE_W-1:0] w_rd;
    logic [ple_pkg::IDX_W-1:0]   w_fidx;
    ple_pkg::t_status            w_fstat;

    assign w_req    = i_s_axis_tdata[2:0];
    assign w_pos    = i_s_axis_tdata[9:3];
    assign w_at_end = i_s_axis_tdata[10];
    assign w_value  = i_s_axis_tdata[26:11];
    assign w_val    = EW'(w_value);

    assign o_s_axis_tready = (r_state == ST_IDLE) && i_rst_n;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_load      = (r_state == ST_BUSY) && (r_cnt == '0)
                             && (!r_out_valid || i_m_axis_tready);

    assign w_count_x = CMPW'(r_count);
    assign w_eff_pos = (w_req == ple_pkg::REQ_INSERT && w_at_end) ? w_count_x
                                                                   : CMPW'(w_pos);

    always_comb begin
        n_mode  = ple_pkg::MODE_READ;
        n_stat  = ple_pkg::STAT_OK;
        n_count = r_count;
        case (w_req)
            ple_pkg::REQ_GET: begin
                if (!(w_eff_pos < w_count_x)) begin
                    n_stat = ple_pkg::STAT_BADPOS;
                end
            end
            ple_pkg::REQ_INSERT: begin
                if (w_eff_pos > w_count_x) begin
                    n_stat = ple_pkg::STAT_BADPOS;
                end else if (r_count == CW'(CAPACITY)) begin
                    n_stat = ple_pkg::STAT_FULL;
                end else begin
                    n_mode  = ple_pkg::MODE_INSERT;
                    n_count = r_count + CW'(1);
                end
            end
            ple_pkg::REQ_REMOVE: begin
                if (w_eff_pos < w_count_x) begin
                    n_mode  = ple_pkg::MODE_REMOVE;
                    n_count = r_count - CW'(1);
                end else begin
                    n_stat = ple_pkg::STAT_BADPOS;
                end
            end
            ple_pkg::REQ_REPLACE: begin
                if (w_eff_pos < w_count_x) begin
                    n_mode = ple_pkg::MODE_REPLACE;
                end else begin
                    n_stat = ple_pkg::STAT_BADPOS;
                end
            end
            ple_pkg::REQ_SEARCH: begin
                n_mode = ple_pkg::MODE_SEARCH;
            end
            ple_pkg::REQ_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_mode = ple_pkg::MODE_READ;
            end
        endcase
    end

    assign w_ctl.en   = w_in_acc;
    assign w_ctl.mode = n_mode;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [EW-1:0] w_left, w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_entry[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_entry[g];
        end else begin : g_mid_r
            assign w_right = w_entry[g+1];
        end
        ple_cell #(
            .EW   (EW),
            .CMPW (CMPW),
            .IDX  (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_pos   (w_eff_pos),
            .i_count (w_count_x),
            .i_val   (w_val),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[g]),
            .o_hit   (w_lhit[g]),
            .o_data  (w_ldata[g])
        );
    end

    ple_tree #(
        .N  (CAPACITY),
        .EW (EW)
    ) u_tree (
        .i_clk  (i_clk),
        .i_hit  (w_lhit),
        .i_data (w_ldata),
        .o_hit  (w_root_hit),
        .o_idx  (w_root_idx),
        .o_data (w_root_data)
    );

    always_comb begin
        w_rd    = '0;
        w_fidx  = '0;
        w_fstat = r_stat;
        case (r_req)
            ple_pkg::REQ_GET,
            ple_pkg::REQ_REMOVE: begin
                if (r_stat == ple_pkg::STAT_OK) begin
                    w_rd = ple_pkg::VALUE_W'(w_root_data);
                end
            end
            ple_pkg::REQ_SEARCH: begin
                if (w_root_hit) begin
                    w_fidx  = ple_pkg::IDX_W'(w_root_idx);
                    w_fstat = ple_pkg::STAT_OK;
                end else begin
                    w_fstat = ple_pkg::STAT_NOTFOUND;
                end
            end
            default: begin
                w_rd = '0;
            end
        endcase
        n_out_data = {1'b0, ple_pkg::CNT_W'(r_count), w_fstat, w_fidx, w_rd};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_count <= n_count;
                r_cnt   <= TW'(L);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - TW'(1);
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_req  <= w_req;
            r_stat <= n_stat;
        end
        if (w_out_load) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    `PLE_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(CAPACITY))
    `PLE_ASSERT(a_acc_busy, i_clk, i_rst_n, w_in_acc |=> r_state == ST_BUSY)
    `PLE_ASSERT(a_load_drained, i_clk, i_rst_n, w_out_load |-> r_cnt == '0)
    `PLE_ASSERT(a_load_valid, i_clk, i_rst_n, w_out_load |=> o_m_axis_tvalid)
    `PLE_ASSERT(a_load_idle, i_clk, i_rst_n, w_out_load |=> r_state == ST_IDLE)

endmodule

@@ rtl/ple_cell.sv @@
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds an entry, shifts with its neighbors, and captures a
// hit flag and its entry for the selection tree.
// ----------------------------------------------------------------------------
module ple_cell #(
    parameter int EW   = ple_pkg::ENTRY_WIDTH,
    parameter int CMPW = ple_pkg::POS_W,
    parameter int IDX  = 0
) (
    input  logic                i_clk,
    input  ple_pkg::t_cell_ctl  i_ctl,
    input  logic [CMPW-1:0]     i_pos,
    input  logic [CMPW-1:0]     i_count,
    input  logic [EW-1:0]       i_val,
    input  logic [EW-1:0]       i_left,
    input  logic [EW-1:0]       i_right,
    output logic [EW-1:0]       o_entry,
    output logic                o_hit,
    output logic [EW-1:0]       o_data
);

    logic [EW-1:0] r_entry, n_entry;
    logic          r_hit, n_hit;
    logic          w_eq, w_above, w_live;

    assign w_eq    = (i_pos == CMPW'(IDX));
    assign w_above = (i_pos < CMPW'(IDX));
    assign w_live  = (CMPW'(IDX) < i_count);

    always_comb begin
        n_entry = r_entry;
        n_hit   = w_eq;
        case (i_ctl.mode)
            ple_pkg::MODE_INSERT: begin
                if (w_above) begin
                    n_entry = i_left;
                end else if (w_eq) begin
                    n_entry = i_val;
                end
            end
            ple_pkg::MODE_REMOVE: begin
                if (w_eq || w_above) begin
                    n_entry = i_right;
                end
            end
            ple_pkg::MODE_REPLACE: begin
                if (w_eq) begin
                    n_entry = i_val;
                end
            end
            ple_pkg::MODE_SEARCH: begin
                n_hit = w_live && (r_entry == i_val);
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_entry <= n_entry;
            r_hit   <= n_hit;
            o_data  <= r_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;

endmodule

@@ rtl/ple_tree.sv @@
// ----------------------------------------------------------------------------
// ple_tree
// Registered first-hit tree over the cell row; one level per cycle.
// ----------------------------------------------------------------------------
module ple_tree #(
    parameter int N  = ple_pkg::CAPACITY,
    parameter int EW = ple_pkg::ENTRY_WIDTH
) (
    input  logic                   i_clk,
    input  logic [N-1:0]           i_hit,
    input  logic [EW-1:0]          i_data [N],
    output logic                   o_hit,
    output logic [$clog2(N)-1:0]   o_idx,
    output logic [EW-1:0]          o_data
);

    localparam int L  = $clog2(N);
    localparam int P  = 2 ** L;
    localparam int IW = L;

    logic [P-1:0]  w_lhit;
    logic [EW-1:0] w_ldata [P];

    logic          r_hit  [1:P-1];
    logic [IW-1:0] r_idx  [1:P-1];
    logic [EW-1:0] r_data [1:P-1];

    for (genvar g = 0; g < P; g++) begin : g_leaf
        if (g < N) begin : g_real
            assign w_lhit[g]  = i_hit[g];
            assign w_ldata[g] = i_data[g];
        end else begin : g_pad
            assign w_lhit[g]  = 1'b0;
            assign w_ldata[g] = '0;
        end
    end

    for (genvar k = 1; k < P; k++) begin : g_node
        logic          w_ah, w_bh;
        logic [IW-1:0] w_ai, w_bi;
        logic [EW-1:0] w_ad, w_bd;
        if (2 * k >= P) begin : g_from_leaf
            assign w_ah = w_lhit[2*k-P];
            assign w_ai = IW'(2*k-P);
            assign w_ad = w_ldata[2*k-P];
            assign w_bh = w_lhit[2*k+1-P];
            assign w_bi = IW'(2*k+1-P);
            assign w_bd = w_ldata[2*k+1-P];
        end else begin : g_from_node
            assign w_ah = r_hit[2*k];
            assign w_ai = r_idx[2*k];
            assign w_ad = r_data[2*k];
            assign w_bh = r_hit[2*k+1];
            assign w_bi = r_idx[2*k+1];
            assign w_bd = r_data[2*k+1];
        end
        always_ff @(posedge i_clk) begin
            r_hit[k]  <= w_ah || w_bh;
            r_idx[k]  <= w_ah ? w_ai : w_bi;
            r_data[k] <= w_ah ? w_ad : w_bd;
        end
    end

    assign o_hit  = r_hit[1];
    assign o_idx  = r_idx[1];
    assign o_data = r_data[1];

endmodule
